// ===== hdl/csched_pkg.sv =====
// ----------------------------------------------------------------------------
// csched_pkg: shared types and constants of the process scheduler
// Process record, list-cell control, state codes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none
package csched_pkg;

	localparam int SLOTS = 16;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [7:0] QUANTUM_RESET = 8'd10;

	localparam logic [1:0] CFG_ALGORITHM = 2'd0;
	localparam logic [1:0] CFG_PREEMPT   = 2'd1;
	localparam logic [1:0] CFG_QUANTUM   = 2'd2;

	localparam logic [1:0] ALG_FCFS  = 2'd0;
	localparam logic [1:0] ALG_SJF   = 2'd1;
	localparam logic [1:0] ALG_PRIO  = 2'd2;
	localparam logic [1:0] ALG_RR    = 2'd3;

	localparam logic [1:0] KIND_TERM   = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;

	localparam logic CMD_ARRIVAL = 1'b0;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  cpu_left;
		logic [7:0]  io_left;
		logic [7:0]  prio;
		logic [15:0] stamp;
		logic [15:0] wt;
		logic [15:0] tt;
	} proc_rec_t;

	typedef enum logic [1:0] {
		SEL_KEEP,
		SEL_NEXT,
		SEL_EXT
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      age;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_WAITROT,
		ST_RUN,
		ST_STATUS
	} state_t;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/csched_if.sv =====
// ----------------------------------------------------------------------------
// csched_if: scheduler channel interfaces
// Valid/ready channels for arrival/tick beats and for result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface csched_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] proc_id;
	logic [7:0] cpu_burst;
	logic [7:0] io_burst;
	logic [7:0] prio_level;

	modport source (output valid, cmd, proc_id, cpu_burst, io_burst, prio_level,
		input ready);
	modport sink (input valid, cmd, proc_id, cpu_burst, io_burst, prio_level,
		output ready);
endinterface

interface csched_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  report_id;
	logic [15:0] waiting_time;
	logic [15:0] turnaround_time;
	logic        running_valid;
	logic        preempted;
	logic        accepted;
	logic        last;

	modport source (output valid, kind, report_id, waiting_time, turnaround_time,
		running_valid, preempted, accepted, last, input ready);
	modport sink (input valid, kind, report_id, waiting_time, turnaround_time,
		running_valid, preempted, accepted, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/csched_cell.sv =====
// ----------------------------------------------------------------------------
// csched_cell: one list entry
// Holds a process record; keeps it, takes its neighbor's or an external one,
// and optionally ages the waiting and turnaround counters.
// ----------------------------------------------------------------------------
`default_nettype none
module csched_cell (
	input  wire logic                   clk,
	input  wire csched_pkg::cell_ctrl_t ctrl,
	input  wire csched_pkg::proc_rec_t  next_rec,
	input  wire csched_pkg::proc_rec_t  ext_rec,
	output csched_pkg::proc_rec_t       rec
);
	import csched_pkg::*;

	proc_rec_t rec_q;
	proc_rec_t src;
	proc_rec_t upd;

	always_comb begin
		case (ctrl.sel)
			SEL_NEXT: src = next_rec;
			SEL_EXT:  src = ext_rec;
			default:  src = rec_q;
		endcase
		upd = src;
		if (ctrl.age) begin
			upd.wt = sat_inc16(src.wt);
			upd.tt = sat_inc16(src.tt);
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= upd;
	end

	assign rec = rec_q;
endmodule
`default_nettype wire

// ===== hdl/cpu_process_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// cpu_process_scheduler_core: tick-driven process scheduler
// Ready and wait lists as rows of shifting cells, with a sequencer on top.
// ----------------------------------------------------------------------------
// An arrival beat is accepted while idle and its acknowledge beat is valid
// on the next cycle. A tick beat keeps the input channel busy while the
// ready list is scanned (one cell compared per cycle while looking for the
// best candidate), the pick is decided, the wait list rotates through its
// head cell once (one entry per cycle unless the result channel stalls a
// termination beat, which is emitted for each finished process) and the
// runner runs. A tick ends with a status beat. Configuration writes are
// taken at any time, but only while idle are they meaningful.
`default_nettype none
module cpu_process_scheduler_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	csched_in_if.sink       in_ch,
	csched_out_if.source    out_ch
);
	import csched_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic [1:0] algorithm_q;
	logic       preempt_q;
	logic [7:0] quantum_q;

	state_t state_q, state_d;

	proc_rec_t  rrec [SLOTS];
	proc_rec_t  wrec [SLOTS];
	cell_ctrl_t rctl [SLOTS];
	cell_ctrl_t wctl [SLOTS];
	proc_rec_t  rnext [SLOTS];
	proc_rec_t  wnext [SLOTS];
	proc_rec_t  r_ext, w_ext;

	logic [CNT_W-1:0] rlen_q, wlen_q, wrem_q, idx_q;
	logic [IDX_W-1:0] best_pos_q;
	logic [7:0]       best_key_q;
	logic [15:0]      best_stamp_q;
	proc_rec_t        run_q;
	logic             rv_q;
	logic [7:0]       slice_q;
	logic [15:0]      tick_q;
	logic             pre_q, ran_q;
	logic [7:0]       ran_id_q;

	logic        ovalid_q;
	logic [1:0]  okind_q;
	logic [7:0]  oid_q;
	logic [15:0] owt_q, ott_q;
	logic        orv_q, opre_q, oacc_q, olast_q;

	logic        ofree;
	logic        in_acc;
	logic        by_prio;
	logic [IDX_W-1:0] rd_addr;
	proc_rec_t   rd_rec;
	logic [7:0]  rd_key, run_key;
	logic        cand_better, run_beaten;
	logic        take, app, pre;
	logic [IDX_W-1:0] pos;
	logic        table_full;
	proc_rec_t   arr_rec, head_upd, run_upd;
	logic        head_done;

	// result beat to load this cycle
	logic        emit;
	logic [1:0]  e_kind;
	logic [7:0]  e_id;
	logic [15:0] e_wt, e_tt;
	logic        e_rv, e_pre, e_acc, e_last;

	assign ofree   = !ovalid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && ofree;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign by_prio = (algorithm_q == ALG_PRIO);

	assign rd_addr = (state_q == ST_SCAN) ? idx_q[IDX_W-1:0] : pos;
	assign rd_rec  = rrec[rd_addr];
	assign rd_key  = by_prio ? rd_rec.prio : rd_rec.cpu_left;
	assign run_key = by_prio ? run_q.prio : run_q.cpu_left;
	assign cand_better = (rd_key < best_key_q) ||
		((rd_key == best_key_q) && (rd_rec.stamp < best_stamp_q));
	assign run_beaten = (run_key > best_key_q) ||
		((run_key == best_key_q) && (run_q.stamp > best_stamp_q));

	assign table_full = ({1'b0, rlen_q} + {1'b0, wlen_q} + {{CNT_W{1'b0}}, rv_q})
		>= (CNT_W + 1)'(SLOTS);

	always_comb begin
		arr_rec.id       = in_ch.proc_id;
		arr_rec.cpu_left = in_ch.cpu_burst;
		arr_rec.io_left  = in_ch.io_burst;
		arr_rec.prio     = in_ch.prio_level;
		arr_rec.stamp    = tick_q;
		arr_rec.wt       = 16'd0;
		arr_rec.tt       = 16'd0;

		head_upd = wrec[0];
		head_upd.wt = sat_inc16(wrec[0].wt);
		head_upd.tt = sat_inc16(wrec[0].tt);
		head_upd.io_left = (wrec[0].io_left != 8'd0) ? wrec[0].io_left - 8'd1 : 8'd0;
		head_done = (head_upd.io_left == 8'd0);

		run_upd = run_q;
		run_upd.cpu_left = (run_q.cpu_left != 8'd0) ? run_q.cpu_left - 8'd1 : 8'd0;
		run_upd.tt = sat_inc16(run_q.tt);
	end

	// pick decision for the current tick
	always_comb begin
		take = 1'b0;
		app  = 1'b0;
		pre  = 1'b0;
		pos  = '0;
		if (rlen_q != '0) begin
			case (algorithm_q)
				ALG_SJF, ALG_PRIO: begin
					pos = best_pos_q;
					if (!rv_q) begin
						take = 1'b1;
					end else if (preempt_q && run_beaten) begin
						take = 1'b1;
						app  = 1'b1;
						pre  = 1'b1;
					end
				end
				ALG_RR: begin
					if (!rv_q) begin
						take = 1'b1;
					end else if (slice_q >= quantum_q) begin
						take = 1'b1;
						app  = 1'b1;
						pre  = 1'b1;
					end
				end
				default: take = !rv_q;
			endcase
		end
	end

	// cell controls
	always_comb begin
		r_ext = (state_q == ST_DECIDE) ? run_q : arr_rec;
		w_ext = (state_q == ST_WAITROT) ? head_upd : run_q;
		for (int k = 0; k < SLOTS; k++) begin
			rnext[k] = (k < SLOTS - 1) ? rrec[(k + 1) % SLOTS] : r_ext;
			wnext[k] = (k < SLOTS - 1) ? wrec[(k + 1) % SLOTS] : w_ext;
			rctl[k].sel = SEL_KEEP;
			rctl[k].age = 1'b0;
			wctl[k].sel = SEL_KEEP;
			wctl[k].age = 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.cmd == CMD_ARRIVAL && !table_full &&
							CNT_W'(k) == rlen_q)
						rctl[k].sel = SEL_EXT;
				end
				ST_DECIDE: begin
					rctl[k].age = 1'b1;
					if (take && IDX_W'(k) >= pos) begin
						if (app && CNT_W'(k) == rlen_q - CNT_W'(1))
							rctl[k].sel = SEL_EXT;
						else
							rctl[k].sel = SEL_NEXT;
					end
				end
				ST_WAITROT: begin
					if (wrem_q != '0 && (!head_done || ofree)) begin
						if (!head_done && CNT_W'(k) == wlen_q - CNT_W'(1))
							wctl[k].sel = SEL_EXT;
						else
							wctl[k].sel = SEL_NEXT;
					end
				end
				ST_RUN: begin
					if (rv_q && run_q.io_left != 8'd0 && CNT_W'(k) == wlen_q)
						wctl[k].sel = SEL_EXT;
				end
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cells
		csched_cell u_rcell (
			.clk      (clk),
			.ctrl     (rctl[g]),
			.next_rec (rnext[g]),
			.ext_rec  (r_ext),
			.rec      (rrec[g])
		);
		csched_cell u_wcell (
			.clk      (clk),
			.ctrl     (wctl[g]),
			.next_rec (wnext[g]),
			.ext_rec  (w_ext),
			.rec      (wrec[g])
		);
	end

	// next state and result beat
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		e_kind  = KIND_STATUS;
		e_id    = 8'd0;
		e_wt    = 16'd0;
		e_tt    = 16'd0;
		e_rv    = 1'b0;
		e_pre   = 1'b0;
		e_acc   = 1'b0;
		e_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_ch.cmd == CMD_ARRIVAL) begin
						emit   = 1'b1;
						e_kind = KIND_ACK;
						e_id   = in_ch.proc_id;
						e_acc  = !table_full;
						e_last = 1'b1;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q >= rlen_q)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = ST_WAITROT;
			ST_WAITROT: begin
				if (wrem_q == '0) begin
					state_d = ST_RUN;
				end else if (head_done && ofree) begin
					emit   = 1'b1;
					e_kind = KIND_TERM;
					e_id   = head_upd.id;
					e_wt   = head_upd.wt;
					e_tt   = head_upd.tt;
				end
			end
			ST_RUN: begin
				if (rv_q && run_q.io_left == 8'd0 && run_upd.cpu_left == 8'd0) begin
					if (ofree) begin
						emit    = 1'b1;
						e_kind  = KIND_TERM;
						e_id    = run_q.id;
						e_wt    = run_q.wt;
						e_tt    = run_upd.tt;
						state_d = ST_STATUS;
					end
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (ofree) begin
					emit    = 1'b1;
					e_kind  = KIND_STATUS;
					e_id    = ran_q ? ran_id_q : 8'd0;
					e_rv    = ran_q;
					e_pre   = pre_q;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algorithm_q <= ALG_FCFS;
			preempt_q   <= 1'b0;
			quantum_q   <= QUANTUM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALGORITHM: algorithm_q <= cfg_data[1:0];
				CFG_PREEMPT:   preempt_q   <= cfg_data[0];
				CFG_QUANTUM:   quantum_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rlen_q  <= '0;
			wlen_q  <= '0;
			wrem_q  <= '0;
			idx_q   <= '0;
			rv_q    <= 1'b0;
			slice_q <= 8'd0;
			tick_q  <= 16'd0;
			pre_q   <= 1'b0;
			ran_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.cmd == CMD_ARRIVAL) begin
							if (!table_full)
								rlen_q <= rlen_q + CNT_W'(1);
						end else begin
							idx_q <= CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (idx_q < rlen_q)
						idx_q <= idx_q + CNT_W'(1);
				end
				ST_DECIDE: begin
					if (take) begin
						rv_q    <= 1'b1;
						slice_q <= 8'd0;
						if (!app)
							rlen_q <= rlen_q - CNT_W'(1);
					end
					pre_q  <= pre;
					wrem_q <= wlen_q;
				end
				ST_WAITROT: begin
					if (wrem_q != '0 && (!head_done || ofree)) begin
						wrem_q <= wrem_q - CNT_W'(1);
						if (head_done)
							wlen_q <= wlen_q - CNT_W'(1);
					end
				end
				ST_RUN: begin
					if (!rv_q) begin
						ran_q <= 1'b0;
					end else if (run_q.io_left != 8'd0) begin
						wlen_q <= wlen_q + CNT_W'(1);
						rv_q   <= 1'b0;
						ran_q  <= 1'b0;
					end else if (run_upd.cpu_left != 8'd0 || ofree) begin
						ran_q <= 1'b1;
						if (slice_q != 8'hFF)
							slice_q <= slice_q + 8'd1;
						if (run_upd.cpu_left == 8'd0)
							rv_q <= 1'b0;
					end
				end
				ST_STATUS: begin
					if (ofree)
						tick_q <= tick_q + 16'd1;
				end
				default: ;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				best_pos_q   <= '0;
				best_key_q   <= by_prio ? rrec[0].prio : rrec[0].cpu_left;
				best_stamp_q <= rrec[0].stamp;
			end
			ST_SCAN: begin
				if (idx_q < rlen_q && cand_better) begin
					best_pos_q   <= idx_q[IDX_W-1:0];
					best_key_q   <= rd_key;
					best_stamp_q <= rd_rec.stamp;
				end
			end
			ST_DECIDE: begin
				if (take)
					run_q <= rd_rec;
			end
			ST_RUN: begin
				// A finishing runner waits here until its report beat can leave.
				if (rv_q && run_q.io_left == 8'd0 &&
						(run_upd.cpu_left != 8'd0 || ofree)) begin
					run_q    <= run_upd;
					ran_id_q <= run_q.id;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			okind_q <= e_kind;
			oid_q   <= e_id;
			owt_q   <= e_wt;
			ott_q   <= e_tt;
			orv_q   <= e_rv;
			opre_q  <= e_pre;
			oacc_q  <= e_acc;
			olast_q <= e_last;
		end
	end

	assign out_ch.valid           = ovalid_q;
	assign out_ch.kind            = okind_q;
	assign out_ch.report_id       = oid_q;
	assign out_ch.waiting_time    = owt_q;
	assign out_ch.turnaround_time = ott_q;
	assign out_ch.running_valid   = orv_q;
	assign out_ch.preempted       = opre_q;
	assign out_ch.accepted        = oacc_q;
	assign out_ch.last            = olast_q;
endmodule
`default_nettype wire

// ===== test/tb_csched_if.sv =====
// ----------------------------------------------------------------------------
// tb_csched_if: testbench copy point for scheduler channels
// The channel interfaces come from the RTL; this file holds the beat types
// that the test bench uses to keep expected and observed results.
// ----------------------------------------------------------------------------
package tb_csched_types;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  report_id;
		logic [15:0] waiting_time;
		logic [15:0] turnaround_time;
		logic        running_valid;
		logic        preempted;
		logic        accepted;
		logic        last;
	} result_beat_t;

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: scheduler test bench
// Sends arrival and tick beats under all four policies, predicts every result
// beat with a behavioral scheduler, and compares each beat in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import csched_pkg::*;
	import tb_csched_types::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	csched_in_if  in_ch();
	csched_out_if out_ch();

	cpu_process_scheduler_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted scheduler state.
	logic [1:0]  p_alg;
	logic        p_preempt;
	logic [7:0]  p_quantum;
	logic [7:0]  pid [SLOTS];
	logic [7:0]  pcpu [SLOTS];
	logic [7:0]  pio [SLOTS];
	logic [7:0]  pprio [SLOTS];
	logic [15:0] pstamp [SLOTS];
	logic [15:0] pwt [SLOTS];
	logic [15:0] ptt [SLOTS];
	logic [SLOTS-1:0] pbusy;
	int          ready_q [$];
	int          io_q [$];
	int          runner;
	logic        runner_valid;
	logic [7:0]  slice;
	logic [15:0] now_tick;

	result_beat_t pending_results [$];
	int  errors = 0;
	int  beats_seen = 0;
	int  terms_seen = 0;
	int  idle_cycles = 0;
	bit  tx_bursty = 1'b1;

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic result_beat_t mk(input logic [1:0] k, input logic [7:0] id,
		input logic [15:0] w, input logic [15:0] t, input logic rv, input logic pr,
		input logic ac, input logic l);
		result_beat_t r;
		r.kind = k; r.report_id = id; r.waiting_time = w; r.turnaround_time = t;
		r.running_valid = rv; r.preempted = pr; r.accepted = ac; r.last = l;
		return r;
	endfunction

	function automatic int best_pos(input bit by_prio);
		int b;
		logic [7:0] kb, kc;
		b = 0;
		for (int i = 1; i < ready_q.size(); i++) begin
			kc = by_prio ? pprio[ready_q[i]] : pcpu[ready_q[i]];
			kb = by_prio ? pprio[ready_q[b]] : pcpu[ready_q[b]];
			if (kc < kb || (kc == kb && pstamp[ready_q[i]] < pstamp[ready_q[b]]))
				b = i;
		end
		return b;
	endfunction

	task automatic grab(input int pos);
		runner = ready_q[pos];
		runner_valid = 1'b1;
		ready_q.delete(pos);
	endtask

	task automatic predict_reset();
		p_alg = ALG_FCFS; p_preempt = 1'b0; p_quantum = QUANTUM_RESET;
		pbusy = '0; ready_q = {}; io_q = {};
		runner = 0; runner_valid = 1'b0; slice = '0; now_tick = '0;
	endtask

	task automatic predict_beat(input logic cmd, input logic [7:0] id,
		input logic [7:0] cpu, input logic [7:0] io, input logic [7:0] pr);
		int s, prev_slot, pos, i;
		logic prev_valid, pre;
		bit by_prio;
		logic [7:0] kr, kb;
		logic [7:0] ran_id;
		logic ran;
		if (cmd == CMD_ARRIVAL) begin
			s = -1;
			for (i = SLOTS - 1; i >= 0; i--)
				if (!pbusy[i]) s = i;
			if (s < 0) begin
				pending_results.push_back(mk(KIND_ACK, id, 16'd0, 16'd0, 1'b0, 1'b0,
					1'b0, 1'b1));
				return;
			end
			pbusy[s] = 1'b1;
			pid[s] = id; pcpu[s] = cpu; pio[s] = io; pprio[s] = pr;
			pstamp[s] = now_tick; pwt[s] = '0; ptt[s] = '0;
			ready_q.push_back(s);
			pending_results.push_back(mk(KIND_ACK, id, 16'd0, 16'd0, 1'b0, 1'b0,
				1'b1, 1'b1));
			return;
		end
		prev_valid = runner_valid; prev_slot = runner; pre = 1'b0;
		ran = 1'b0; ran_id = '0;
		if (ready_q.size() != 0) begin
			if (p_alg == ALG_FCFS) begin
				if (!runner_valid) grab(0);
			end else if (p_alg == ALG_SJF || p_alg == ALG_PRIO) begin
				by_prio = (p_alg == ALG_PRIO);
				pos = best_pos(by_prio);
				if (!runner_valid) grab(pos);
				else if (p_preempt) begin
					kr = by_prio ? pprio[runner] : pcpu[runner];
					kb = by_prio ? pprio[ready_q[pos]] : pcpu[ready_q[pos]];
					if (kr > kb || (kr == kb && pstamp[runner] > pstamp[ready_q[pos]])) begin
						ready_q.push_back(runner);
						grab(pos);
						pre = 1'b1;
					end
				end
			end else begin
				if (!runner_valid) grab(0);
				else if (slice >= p_quantum) begin
					ready_q.push_back(runner);
					grab(0);
					pre = 1'b1;
				end
			end
		end
		if (prev_valid != runner_valid || (runner_valid && prev_slot != runner))
			slice = '0;
		foreach (ready_q[k]) begin
			pwt[ready_q[k]] = bump(pwt[ready_q[k]]);
			ptt[ready_q[k]] = bump(ptt[ready_q[k]]);
		end
		i = 0;
		while (i < io_q.size()) begin
			s = io_q[i];
			pwt[s] = bump(pwt[s]);
			ptt[s] = bump(ptt[s]);
			if (pio[s] > 0) pio[s]--;
			if (pio[s] == 0) begin
				pending_results.push_back(mk(KIND_TERM, pid[s], pwt[s], ptt[s], 1'b0,
					1'b0, 1'b0, 1'b0));
				pbusy[s] = 1'b0;
				io_q.delete(i);
			end else
				i++;
		end
		if (runner_valid && pio[runner] > 0) begin
			io_q.push_back(runner);
			runner_valid = 1'b0;
		end
		if (runner_valid) begin
			s = runner;
			ran = 1'b1; ran_id = pid[s];
			if (pcpu[s] > 0) pcpu[s]--;
			ptt[s] = bump(ptt[s]);
			if (slice != 8'hFF) slice++;
			if (pcpu[s] == 0) begin
				pending_results.push_back(mk(KIND_TERM, pid[s], pwt[s], ptt[s], 1'b0,
					1'b0, 1'b0, 1'b0));
				pbusy[s] = 1'b0;
				runner_valid = 1'b0;
			end
		end
		pending_results.push_back(mk(KIND_STATUS, ran_id, 16'd0, 16'd0, ran, pre,
			1'b0, 1'b1));
		now_tick++;
	endtask

	// One beat on the input channel, with bursty random gaps while tx_bursty
	// is set. Valid stays high after an accepted beat until the next beat, a
	// gap, a drain or a register write takes it down.
	task automatic send_beat(input logic cmd, input logic [7:0] id,
		input logic [7:0] cpu, input logic [7:0] io, input logic [7:0] pr);
		if (tx_bursty && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd; in_ch.proc_id <= id; in_ch.cpu_burst <= cpu;
		in_ch.io_burst <= io; in_ch.prio_level <= pr;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_beat(cmd, id, cpu, io, pr);
	endtask

	task automatic arrive(input logic [7:0] id, input logic [7:0] cpu,
		input logic [7:0] io, input logic [7:0] pr);
		send_beat(CMD_ARRIVAL, id, cpu, io, pr);
	endtask

	task automatic tick();
		send_beat(~CMD_ARRIVAL, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		in_ch.valid <= 1'b0;
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_ALGORITHM) p_alg = val[1:0];
		else if (idx == CFG_PREEMPT) p_preempt = val[0];
		else if (idx == CFG_QUANTUM) p_quantum = val;
	endtask

	// Run every process to completion so each phase starts from an empty table.
	task automatic flush_processes();
		int guard;
		guard = 0;
		while ((pbusy != '0) && guard < 1200) begin
			tick();
			guard++;
		end
		drain();
	endtask

	task automatic test_fcfs_extremes();
		set_reg(CFG_ALGORITHM, {6'd0, ALG_FCFS});
		arrive(8'h00, 8'h00, 8'h00, 8'h00);
		arrive(8'hFF, 8'h03, 8'h00, 8'hFF);
		arrive(8'hA5, 8'h02, 8'h02, 8'h5A);
		arrive(8'h5A, 8'h01, 8'h00, 8'h00);
		repeat (8) tick();
		flush_processes();
	endtask

	task automatic test_table_full();
		for (int i = 0; i < SLOTS + 2; i++)
			arrive(8'(i + 8'h30), 8'h01, 8'h00, 8'(i));
		flush_processes();
	endtask

	task automatic test_priority_preempt();
		set_reg(CFG_ALGORITHM, {6'd0, ALG_PRIO});
		set_reg(CFG_PREEMPT, 8'd1);
		arrive(8'h10, 8'h05, 8'h00, 8'h80);
		tick();
		arrive(8'h11, 8'h02, 8'h00, 8'h10);
		arrive(8'h12, 8'h02, 8'h00, 8'h10);
		repeat (3) tick();
		flush_processes();
	endtask

	task automatic test_round_robin_quantum();
		set_reg(CFG_ALGORITHM, {6'd0, ALG_RR});
		set_reg(CFG_QUANTUM, 8'd1);
		arrive(8'h20, 8'h04, 8'h00, 8'h00);
		arrive(8'h21, 8'h03, 8'h00, 8'h00);
		repeat (4) tick();
		flush_processes();
		set_reg(CFG_QUANTUM, 8'd255);
		arrive(8'h22, 8'h02, 8'h00, 8'h00);
		flush_processes();
	endtask

	// Random mixes of arrivals and ticks under one policy setting.
	task automatic test_random_phase(input logic [1:0] alg, input logic pe,
		input logic [7:0] q, input int count);
		set_reg(CFG_ALGORITHM, {6'd0, alg});
		set_reg(CFG_PREEMPT, {7'd0, pe});
		set_reg(CFG_QUANTUM, q);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 2) == 0 && pbusy != '1)
				arrive(8'($urandom), 8'($urandom_range(0, 7)),
					$urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 4)) : 8'h00,
					$urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom));
			else
				tick();
		end
		flush_processes();
	endtask

	// Result checker and receiver stall pattern.
	always @(posedge clk) begin
		result_beat_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = mk(out_ch.kind, out_ch.report_id, out_ch.waiting_time,
				out_ch.turnaround_time, out_ch.running_valid, out_ch.preempted,
				out_ch.accepted, out_ch.last);
			beats_seen++;
			if (got.kind == KIND_TERM) terms_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
		out_ch.ready <= ($time / 800) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.proc_id = '0;
		in_ch.cpu_burst = '0; in_ch.io_burst = '0; in_ch.prio_level = '0;
		out_ch.ready = 1'b0;
		predict_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fcfs_extremes();
		test_table_full();
		test_priority_preempt();
		test_round_robin_quantum();
		test_random_phase(ALG_SJF, 1'b0, 8'd10, 6);
		test_random_phase(ALG_SJF, 1'b1, 8'd10, 6);
		tx_bursty = 1'b0;
		test_random_phase(ALG_PRIO, 1'b0, 8'd3, 6);
		tx_bursty = 1'b1;
		test_random_phase(ALG_RR, 1'b1, 8'd0, 6);
		test_random_phase(ALG_RR, 1'b0, 8'd2, 6);
		test_random_phase(ALG_FCFS, 1'b1, 8'd255, 6);
		drain();
		$display("Covered four policies, preemption, quantum extremes and a full table.");
		$display("Checked %0d result beats, %0d of them terminations.", beats_seen,
			terms_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/csched_pkg.sv
hdl/csched_if.sv
hdl/csched_cell.sv
hdl/cpu_process_scheduler_core.sv
test/tb_csched_if.sv
test/tb_top.sv
